// ===== hdl/ofc_pkg.sv =====
// ----------------------------------------------------------------------------
// ofc_pkg: shared types, constants and font for the OLED page frame composer
// Frame geometry, item kinds, register indexes, the 5x7 font and the
// structs that travel between the composer's units.
// ----------------------------------------------------------------------------
`default_nettype none

package ofc_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 64;
  localparam int TEXT_COLUMNS = 21;

  localparam int PAGE_COUNT = FRAME_HEIGHT / 8;
  localparam int STORE_SIZE = FRAME_WIDTH * PAGE_COUNT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  // Text cells
  localparam int CELL_PITCH = 6;
  localparam int GLYPH_COLS = 5;
  localparam int GX_W       = $clog2(TEXT_COLUMNS * CELL_PITCH);

  // Luminance weights and field widths
  localparam int W_BLUE  = 11;
  localparam int W_GREEN = 59;
  localparam int W_RED   = 30;
  localparam int LUMA_W  = 15;
  localparam logic [LUMA_W-1:0] LUMA_THRESHOLD_RST = 15'd12800;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_GLYPH = 2'd1,
    KIND_PIXEL = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // Register indexes
  localparam logic [1:0] CFG_COLOUR_SOURCE  = 2'd0;
  localparam logic [1:0] CFG_BOTTOM_UP      = 2'd1;
  localparam logic [1:0] CFG_LUMA_THRESHOLD = 2'd2;

  typedef struct packed {
    logic              colour_source;
    logic              bottom_up;
    logic [LUMA_W-1:0] luma_threshold;
  } cfg_t;

  // Prepared pixel update, ready for the read-modify-write
  typedef struct packed {
    logic              on;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
  } pix_t;

  // Five columns of one character, first column in the top byte
  function automatic logic [8*GLYPH_COLS-1:0] font_glyph(input logic [7:0] code);
    logic [7:0]              folded;
    logic [8*GLYPH_COLS-1:0] g;
    folded = code;
    if (code >= "a" && code <= "z") begin
      folded = code - 8'd32;
    end
    case (folded)
      "A": g = 40'h7e1111117e;
      "B": g = 40'h7f49494936;
      "C": g = 40'h3e41414122;
      "D": g = 40'h7f4141221c;
      "E": g = 40'h7f49494941;
      "F": g = 40'h7f09090901;
      "G": g = 40'h3e4149497a;
      "H": g = 40'h7f0808087f;
      "I": g = 40'h00417f4100;
      "J": g = 40'h2040413f01;
      "K": g = 40'h7f08142241;
      "L": g = 40'h7f40404040;
      "M": g = 40'h7f020c027f;
      "N": g = 40'h7f0408107f;
      "O": g = 40'h3e4141413e;
      "P": g = 40'h7f09090906;
      "Q": g = 40'h3e4151215e;
      "R": g = 40'h7f09192946;
      "S": g = 40'h4649494931;
      "T": g = 40'h01017f0101;
      "U": g = 40'h3f4040403f;
      "V": g = 40'h1f2040201f;
      "W": g = 40'h3f4038403f;
      "X": g = 40'h6314081463;
      "Y": g = 40'h0708700807;
      "Z": g = 40'h6151494543;
      "0": g = 40'h3e5149453e;
      "1": g = 40'h00427f4000;
      "2": g = 40'h4261514946;
      "3": g = 40'h2141454b31;
      "4": g = 40'h1814127f10;
      "5": g = 40'h2745454539;
      "6": g = 40'h3c4a494930;
      "7": g = 40'h0171090503;
      "8": g = 40'h3649494936;
      "9": g = 40'h064949291e;
      ".": g = 40'h0060600000;
      ":": g = 40'h0036360000;
      "-": g = 40'h0808080808;
      "/": g = 40'h2010080402;
      ">": g = 40'h0041221408;
      default: g = '0;
    endcase
    return g;
  endfunction

  // One column byte of a character
  function automatic logic [7:0] font_column(input logic [7:0] code, input logic [2:0] col);
    logic [8*GLYPH_COLS-1:0] g;
    g = font_glyph(code);
    return g[8*(GLYPH_COLS-1-int'(col)) +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ofc_if.sv =====
// ----------------------------------------------------------------------------
// ofc_if: channel interfaces of the OLED page frame composer
// Input item, result and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ofc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  logic [2:0] text_row;
  logic [4:0] text_col;
  logic [6:0] pixel_x;
  logic [5:0] pixel_y;
  logic [7:0] byte_blue;
  logic [7:0] byte_green;
  logic [7:0] byte_red;
  logic [9:0] read_address;

  modport source (
    output valid, kind, char_code, text_row, text_col, pixel_x, pixel_y,
           byte_blue, byte_green, byte_red, read_address,
    input  ready
  );
  modport sink (
    input  valid, kind, char_code, text_row, text_col, pixel_x, pixel_y,
           byte_blue, byte_green, byte_red, read_address,
    output ready
  );
endinterface

interface ofc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       pixel_on;

  modport source (output valid, read_data, pixel_on, input ready);
  modport sink   (input valid, read_data, pixel_on, output ready);
endinterface

interface ofc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [14:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ofc_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// ofc_pixel_unit: pixel decision and frame position
// Turns one bitmap pixel into an on/off bit and a frame byte address and
// bit mask; results are registered when the item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module ofc_pixel_unit (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire ofc_pkg::cfg_t cfg,
  input  wire logic [6:0]    pixel_x,
  input  wire logic [5:0]    pixel_y,
  input  wire logic [7:0]    byte_blue,
  input  wire logic [7:0]    byte_green,
  input  wire logic [7:0]    byte_red,
  output ofc_pkg::pix_t      pix
);

  logic [ofc_pkg::LUMA_W-1:0] luma;
  logic                       mono_bit;
  logic                       on;
  logic                       in_frame;
  logic [31:0]                dy;
  ofc_pkg::pix_t              pix_r;
  ofc_pkg::pix_t              pix_nxt;

  // Weigh the colour bytes and pick the source of the pixel bit
  always_comb begin
    luma = ofc_pkg::LUMA_W'(byte_blue)  * ofc_pkg::LUMA_W'(ofc_pkg::W_BLUE)
         + ofc_pkg::LUMA_W'(byte_green) * ofc_pkg::LUMA_W'(ofc_pkg::W_GREEN)
         + ofc_pkg::LUMA_W'(byte_red)   * ofc_pkg::LUMA_W'(ofc_pkg::W_RED);
    mono_bit = byte_blue[~pixel_x[2:0]];
    on = cfg.colour_source ? (luma < cfg.luma_threshold) : mono_bit;
  end

  // Map the source row and build address and mask
  always_comb begin
    in_frame = (32'(pixel_y) < ofc_pkg::FRAME_HEIGHT) && (32'(pixel_x) < ofc_pkg::FRAME_WIDTH);
    dy = cfg.bottom_up ? 32'(ofc_pkg::FRAME_HEIGHT - 1) - 32'(pixel_y) : 32'(pixel_y);
    pix_nxt.on    = on;
    pix_nxt.wr_en = on && in_frame && (dy < 32'(ofc_pkg::PAGE_COUNT * 8));
    pix_nxt.addr  = ofc_pkg::ADDR_W'((dy >> 3) * ofc_pkg::FRAME_WIDTH + 32'(pixel_x));
    pix_nxt.mask  = 8'(1) << dy[2:0];
  end

  // Hold the prepared update for the read-modify-write
  always_ff @(posedge clk) begin
    if (load) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix = pix_r;

endmodule

`default_nettype wire

// ===== hdl/ofc_frame_engine.sv =====
// ----------------------------------------------------------------------------
// ofc_frame_engine: frame store and item sequencer
// Owns the page-format frame memory, sweeps it clear, writes glyph
// columns, does the pixel read-modify-write and serves byte reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ofc_frame_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ofc_in_if.sink             in_chan,
  ofc_out_if.source          out_chan,
  input  wire ofc_pkg::pix_t pix,
  output logic               accept
);

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_GLYPH   = 8'b0000_0100,
    ST_PIX_RD  = 8'b0000_1000,
    ST_PIX_WB  = 8'b0001_0000,
    ST_READ_RD = 8'b0010_0000,
    ST_READ_WB = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

  localparam int A_W = ofc_pkg::ADDR_W;

  state_t state_r, state_nxt;

  // Frame memory
  logic [7:0]     frame_mem [ofc_pkg::STORE_SIZE];
  logic           ram_we;
  logic [A_W-1:0] ram_wa;
  logic [7:0]     ram_wd;
  logic           ram_re;
  logic [A_W-1:0] ram_ra;
  logic [7:0]     ram_rdata_r;

  // Sequencer state
  logic [A_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic           clr_item_r, clr_item_nxt;
  logic [2:0]     col_idx_r, col_idx_nxt;

  // Captured item fields
  logic [1:0]     kind_r;
  logic [7:0]     char_code_r;
  logic [2:0]     text_row_r;
  logic [4:0]     text_col_r;
  logic [9:0]     read_address_r;

  // Result staging and output register
  logic [7:0]     res_data_r, res_data_nxt;
  logic           res_on_r, res_on_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_data_r;
  logic           out_on_r;
  logic           out_load;

  // Glyph placement
  localparam int GX_W_L = ofc_pkg::GX_W;
  logic           glyph_ok;
  logic [GX_W_L-1:0] glyph_x;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    glyph_ok = (32'(text_row_r) < ofc_pkg::PAGE_COUNT)
            && (32'(text_col_r) < ofc_pkg::TEXT_COLUMNS);
    glyph_x  = GX_W_L'(32'(text_col_r) * ofc_pkg::CELL_PITCH + 32'(col_idx_r));
  end

  // Sequence the items and drive the memory ports
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_item_nxt = clr_item_r;
    col_idx_nxt  = col_idx_r;
    res_data_nxt = res_data_r;
    res_on_nxt   = res_on_r;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_wa       = clr_cnt_r;
    ram_wd       = '0;
    ram_re       = 1'b0;
    ram_ra       = pix.addr;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == ofc_pkg::STORE_SIZE - 1) begin
          clr_cnt_nxt  = '0;
          clr_item_nxt = 1'b0;
          res_data_nxt = '0;
          res_on_nxt   = 1'b0;
          state_nxt    = clr_item_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (ofc_pkg::kind_t'(in_chan.kind))
            ofc_pkg::KIND_CLEAR: begin
              clr_item_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            ofc_pkg::KIND_GLYPH: begin
              col_idx_nxt = '0;
              state_nxt   = ST_GLYPH;
            end
            ofc_pkg::KIND_PIXEL: state_nxt = ST_PIX_RD;
            ofc_pkg::KIND_READ:  state_nxt = ST_READ_RD;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_GLYPH: begin
        ram_we      = glyph_ok && (32'(glyph_x) < ofc_pkg::FRAME_WIDTH);
        ram_wa      = A_W'(32'(text_row_r) * ofc_pkg::FRAME_WIDTH + 32'(glyph_x));
        ram_wd      = ofc_pkg::font_column(char_code_r, col_idx_r);
        col_idx_nxt = col_idx_r + 1'b1;
        if (32'(col_idx_r) == ofc_pkg::GLYPH_COLS - 1) begin
          res_data_nxt = '0;
          res_on_nxt   = 1'b0;
          state_nxt    = ST_DONE;
        end
      end
      ST_PIX_RD: begin
        ram_re    = 1'b1;
        ram_ra    = pix.addr;
        state_nxt = ST_PIX_WB;
      end
      ST_PIX_WB: begin
        ram_we       = pix.wr_en;
        ram_wa       = pix.addr;
        ram_wd       = ram_rdata_r | pix.mask;
        res_data_nxt = '0;
        res_on_nxt   = pix.on;
        state_nxt    = ST_DONE;
      end
      ST_READ_RD: begin
        ram_re    = 1'b1;
        ram_ra    = A_W'(read_address_r);
        state_nxt = ST_READ_WB;
      end
      ST_READ_WB: begin
        res_data_nxt = (32'(read_address_r) < ofc_pkg::STORE_SIZE) ? ram_rdata_r : '0;
        res_on_nxt   = 1'b0;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers; reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_item_r  <= 1'b0;
      col_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_item_r  <= clr_item_nxt;
      col_idx_r   <= col_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture item fields and results
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r         <= in_chan.kind;
      char_code_r    <= in_chan.char_code;
      text_row_r     <= in_chan.text_row;
      text_col_r     <= in_chan.text_col;
      read_address_r <= in_chan.read_address;
    end
    res_data_r <= res_data_nxt;
    res_on_r   <= res_on_nxt;
    if (out_load) begin
      out_data_r <= (ofc_pkg::kind_t'(kind_r) == ofc_pkg::KIND_READ) ? res_data_r : '0;
      out_on_r   <= res_on_r;
    end
  end

  // Frame memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ram_we) begin
      frame_mem[ram_wa] <= ram_wd;
    end
    if (ram_re) begin
      ram_rdata_r <= frame_mem[ram_ra];
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_data_r;
  assign out_chan.pixel_on  = out_on_r;

endmodule

`default_nettype wire

// ===== hdl/oled_page_frame_composer.sv =====
// ----------------------------------------------------------------------------
// oled_page_frame_composer: 128x64 page-format frame with text and pixels
// Clears, draws 5x7 glyphs, sets bitmap pixels and reads back frame bytes.
// ----------------------------------------------------------------------------
// Each accepted item runs through its states to ST_DONE, which hands the result
// to the output register once that is free; memory reads are registered and one
// byte is written per cycle.
// Items are taken one at a time: in ready is high only in ST_IDLE.
// Reset: synchronous, active low; registers return to their reset values and
// the frame memory is swept to zero with in ready held low.
// Register writes are taken in any cycle.
`default_nettype none

module oled_page_frame_composer (
  input  wire logic clk,
  input  wire logic rst_n,
  ofc_in_if.sink    in_chan,
  ofc_out_if.source out_chan,
  ofc_cfg_if.sink   cfg_chan
);

  ofc_pkg::cfg_t cfg_r, cfg_nxt;
  ofc_pkg::pix_t pix;
  logic          accept;

  assign cfg_chan.ready = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.addr)
        ofc_pkg::CFG_COLOUR_SOURCE:  cfg_nxt.colour_source  = cfg_chan.data[0];
        ofc_pkg::CFG_BOTTOM_UP:      cfg_nxt.bottom_up      = cfg_chan.data[0];
        ofc_pkg::CFG_LUMA_THRESHOLD: cfg_nxt.luma_threshold = cfg_chan.data;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.colour_source  <= 1'b1;
      cfg_r.bottom_up      <= 1'b1;
      cfg_r.luma_threshold <= ofc_pkg::LUMA_THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ofc_pixel_unit u_pixel (
    .clk        (clk),
    .load       (accept),
    .cfg        (cfg_r),
    .pixel_x    (in_chan.pixel_x),
    .pixel_y    (in_chan.pixel_y),
    .byte_blue  (in_chan.byte_blue),
    .byte_green (in_chan.byte_green),
    .byte_red   (in_chan.byte_red),
    .pix        (pix)
  );

  ofc_frame_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .pix      (pix),
    .accept   (accept)
  );

endmodule

`default_nettype wire

// ===== hdl/ofc_checker.sv =====
// ----------------------------------------------------------------------------
// ofc_checker: port-level checks for the OLED page frame composer
// Watches the item and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ofc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_data,
  input wire logic       out_pixel_on
);

  // A waiting result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_pixel_on))
    else $error("result word changed while stalled");

  // One item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while the previous one is in work");

  // Reset starts the clearing sweep, so no item is taken next
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item taken during the clearing sweep");

  // A result carries a read byte or a pixel bit, never both
  a_one_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_pixel_on && (out_read_data != 8'd0)))
    else $error("result carries both a byte and a pixel bit");

endmodule

bind oled_page_frame_composer ofc_checker u_ofc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_read_data (out_chan.read_data),
  .out_pixel_on  (out_chan.pixel_on)
);

`default_nettype wire

// ===== bench/tb_oled_page_frame_composer.sv =====
// ----------------------------------------------------------------------------
// tb_oled_page_frame_composer: self-checking bench for the page frame composer
// Sends clear, glyph, pixel and read words, keeps a shadow copy of the frame
// and register set, and checks every result word in arrival order. Register
// settings change between phases, only while the composer is idle.
// ----------------------------------------------------------------------------

module tb_oled_page_frame_composer;

  localparam int STALL_LIMIT     = 5000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int MAX_REPORTS     = 10;
  localparam int HOLD_CYCLES     = 400;

  typedef struct packed {
    ofc_pkg::kind_t kind;
    logic [7:0]     char_code;
    logic [2:0]     text_row;
    logic [4:0]     text_col;
    logic [6:0]     pixel_x;
    logic [5:0]     pixel_y;
    logic [7:0]     byte_blue;
    logic [7:0]     byte_green;
    logic [7:0]     byte_red;
    logic [9:0]     read_address;
  } frame_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pixel_on;
  } frame_resp_t;

  // Glyph columns, letter A and digit 0 in the top slot, first column high
  localparam logic [26*40-1:0] ALPHA_ROM = {
    40'h7e1111117e, 40'h7f49494936, 40'h3e41414122, 40'h7f4141221c, 40'h7f49494941,
    40'h7f09090901, 40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100, 40'h2040413f01,
    40'h7f08142241, 40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931, 40'h01017f0101,
    40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f, 40'h6314081463, 40'h0708700807,
    40'h6151494543
  };
  localparam logic [10*40-1:0] DIGIT_ROM = {
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31, 40'h1814127f10,
    40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936, 40'h064949291e
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ofc_in_if  in_bus();
  ofc_out_if out_bus();
  ofc_cfg_if cfg_bus();

  logic        in_valid  = 1'b0;
  frame_cmd_t  in_word   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_value = '0;

  assign in_bus.valid        = in_valid;
  assign in_bus.kind         = in_word.kind;
  assign in_bus.char_code    = in_word.char_code;
  assign in_bus.text_row     = in_word.text_row;
  assign in_bus.text_col     = in_word.text_col;
  assign in_bus.pixel_x      = in_word.pixel_x;
  assign in_bus.pixel_y      = in_word.pixel_y;
  assign in_bus.byte_blue    = in_word.byte_blue;
  assign in_bus.byte_green   = in_word.byte_green;
  assign in_bus.byte_red     = in_word.byte_red;
  assign in_bus.read_address = in_word.read_address;
  assign out_bus.ready       = out_ready;
  assign cfg_bus.valid       = cfg_valid;
  assign cfg_bus.addr        = cfg_index;
  assign cfg_bus.data        = cfg_value;

  oled_page_frame_composer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  frame_cmd_t  pending_q[$];
  frame_resp_t expected_q[$];

  // Shadow frame and registers
  logic [7:0]  shadow_frame [ofc_pkg::STORE_SIZE];
  logic        shadow_colour    = 1'b1;
  logic        shadow_bottom_up = 1'b1;
  logic [14:0] shadow_threshold = ofc_pkg::LUMA_THRESHOLD_RST;

  int   accepted_in    = 0;
  int   mismatch_count = 0;
  int   stall_count    = 0;
  int   hold_left      = 0;
  int   hold_stage     = 0;
  int   recent_addr    = 0;
  logic in_taken       = 1'b0;
  logic calm;
  string font_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.:->/";

  // No idling on either side over this stretch
  assign calm = (accepted_in >= 600) && (accepted_in < 800);

  initial forever #1 clk = ~clk;

  // Apply one word to the shadow frame and work out its result word
  task automatic predict_frame(input frame_cmd_t c, output frame_resp_t r);
    logic [7:0]  up;
    logic [39:0] g;
    logic        on;
    int          x;
    int          dy;
    int          lum;
    r = '0;
    case (c.kind)
      ofc_pkg::KIND_CLEAR: begin
        foreach (shadow_frame[a]) shadow_frame[a] = 8'h00;
      end
      ofc_pkg::KIND_GLYPH: begin
        // Fold lower case, pick the font entry, blank for anything unknown
        up = c.char_code;
        if (up >= 8'h61 && up <= 8'h7a) up = up - 8'h20;
        if (up >= 8'h41 && up <= 8'h5a) begin
          g = ALPHA_ROM[(25 - int'(up - 8'h41)) * 40 +: 40];
        end else if (up >= 8'h30 && up <= 8'h39) begin
          g = DIGIT_ROM[(9 - int'(up - 8'h30)) * 40 +: 40];
        end else begin
          case (up)
            8'h2e:   g = 40'h0060600000;   // dot
            8'h3a:   g = 40'h0036360000;   // colon
            8'h2d:   g = 40'h0808080808;   // dash
            8'h2f:   g = 40'h2010080402;   // slash
            8'h3e:   g = 40'h0041221408;   // greater than
            default: g = '0;
          endcase
        end
        // Cells past the last text column leave the frame alone
        if (int'(c.text_row) < ofc_pkg::PAGE_COUNT &&
            int'(c.text_col) < ofc_pkg::TEXT_COLUMNS) begin
          for (int i = 0; i < ofc_pkg::GLYPH_COLS; i++) begin
            x = int'(c.text_col) * ofc_pkg::CELL_PITCH + i;
            if (x < ofc_pkg::FRAME_WIDTH) begin
              shadow_frame[int'(c.text_row) * ofc_pkg::FRAME_WIDTH + x] =
                g[(ofc_pkg::GLYPH_COLS-1-i)*8 +: 8];
            end
          end
        end
      end
      ofc_pkg::KIND_PIXEL: begin
        if (!shadow_colour) begin
          on = c.byte_blue[3'd7 - c.pixel_x[2:0]];
        end else begin
          lum = int'(c.byte_blue) * ofc_pkg::W_BLUE + int'(c.byte_green) * ofc_pkg::W_GREEN
              + int'(c.byte_red) * ofc_pkg::W_RED;
          on = (lum < int'(shadow_threshold));
        end
        r.pixel_on = on;
        dy = shadow_bottom_up ? ofc_pkg::FRAME_HEIGHT - 1 - int'(c.pixel_y)
                              : int'(c.pixel_y);
        if (on && dy < ofc_pkg::FRAME_HEIGHT && int'(c.pixel_x) < ofc_pkg::FRAME_WIDTH) begin
          x = (dy / 8) * ofc_pkg::FRAME_WIDTH + int'(c.pixel_x);
          shadow_frame[x] = shadow_frame[x] | 8'(1 << (dy % 8));
        end
      end
      default: begin
        if (int'(c.read_address) < ofc_pkg::STORE_SIZE) begin
          r.read_data = shadow_frame[c.read_address];
        end
      end
    endcase
  endtask

  // Monitor: check result words, predict accepted words, track registers
  always @(posedge clk) begin
    frame_resp_t want;
    frame_resp_t got;
    in_taken = in_valid && in_bus.ready;
    if (rst_n) begin
      if (out_bus.valid && out_ready) begin
        got.read_data = out_bus.read_data;
        got.pixel_on  = out_bus.pixel_on;
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result word: read_data %02h pixel_on %0b",
                     got.read_data, got.pixel_on);
          end
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("result mismatch: read_data exp %02h got %02h, pixel_on exp %0b got %0b",
                       want.read_data, got.read_data, want.pixel_on, got.pixel_on);
            end
          end
        end
      end
      if (in_taken) begin
        predict_frame(in_word, want);
        expected_q.push_back(want);
        accepted_in++;
      end
      if (cfg_valid && cfg_bus.ready) begin
        case (cfg_index)
          ofc_pkg::CFG_COLOUR_SOURCE:  shadow_colour    = cfg_value[0];
          ofc_pkg::CFG_BOTTOM_UP:      shadow_bottom_up = cfg_value[0];
          ofc_pkg::CFG_LUMA_THRESHOLD: shadow_threshold = cfg_value;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_bus.ready) || (out_bus.valid && out_ready) ||
        (cfg_valid && cfg_bus.ready)) begin
      stall_count <= 0;
    end else if (stall_count < STALL_LIMIT) begin
      stall_count <= stall_count + 1;
    end else begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Driver: hold the word until taken, then offer the next or idle
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
        in_word  <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus two long hold-offs to back up the input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_stage < 2 && accepted_in >= (hold_stage == 0 ? 300 : 900)) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_stage <= hold_stage + 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  // Wait until every queued word is sent and every result word has come back
  task automatic drain();
    @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_glyph(input logic [7:0] code, input logic [2:0] row,
                            input logic [4:0] col);
    frame_cmd_t c;
    c = '0;
    c.kind      = ofc_pkg::KIND_GLYPH;
    c.char_code = code;
    c.text_row  = row;
    c.text_col  = col;
    pending_q.push_back(c);
  endtask

  task automatic push_pixel(input logic [6:0] x, input logic [5:0] y, input logic [7:0] b,
                            input logic [7:0] g, input logic [7:0] r);
    frame_cmd_t c;
    c = '0;
    c.kind       = ofc_pkg::KIND_PIXEL;
    c.pixel_x    = x;
    c.pixel_y    = y;
    c.byte_blue  = b;
    c.byte_green = g;
    c.byte_red   = r;
    pending_q.push_back(c);
  endtask

  task automatic push_read(input logic [9:0] addr);
    frame_cmd_t c;
    c = '0;
    c.kind         = ofc_pkg::KIND_READ;
    c.read_address = addr;
    pending_q.push_back(c);
  endtask

  // Random word: mostly draws followed by reads aimed at what was just drawn
  task automatic random_word(input logic flip, output frame_cmd_t c);
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    int          pick;
    int          dy;
    r0 = $urandom;
    r1 = $urandom;
    r2 = $urandom;
    c.char_code    = r0[7:0];
    c.text_row     = r0[10:8];
    c.text_col     = r0[15:11];
    c.pixel_x      = r0[22:16];
    c.pixel_y      = r0[28:23];
    c.byte_blue    = r1[7:0];
    c.byte_green   = r1[15:8];
    c.byte_red     = r1[23:16];
    c.read_address = r2[9:0];
    pick = $urandom_range(99);
    if (pick == 0) begin
      c.kind = ofc_pkg::KIND_CLEAR;
    end else if (pick < 26) begin
      c.kind = ofc_pkg::KIND_GLYPH;
      if ($urandom_range(9) < 6) c.char_code = font_chars[$urandom_range(font_chars.len() - 1)];
      if ($urandom_range(9) != 0) c.text_col = 5'($urandom_range(ofc_pkg::TEXT_COLUMNS - 1));
      recent_addr = int'(c.text_row) * ofc_pkg::FRAME_WIDTH
                  + int'(c.text_col) * ofc_pkg::CELL_PITCH
                  + int'($urandom_range(ofc_pkg::CELL_PITCH - 1));
    end else if (pick < 63) begin
      c.kind = ofc_pkg::KIND_PIXEL;
      case ($urandom_range(3))
        0: begin
          c.byte_blue  = 8'h00;
          c.byte_green = 8'h00;
          c.byte_red   = 8'h00;
        end
        1: begin
          c.byte_blue  = 8'hff;
          c.byte_green = 8'hff;
          c.byte_red   = 8'hff;
        end
        default: ;
      endcase
      dy = flip ? ofc_pkg::FRAME_HEIGHT - 1 - int'(c.pixel_y) : int'(c.pixel_y);
      recent_addr = (dy / 8) * ofc_pkg::FRAME_WIDTH + int'(c.pixel_x);
    end else begin
      c.kind = ofc_pkg::KIND_READ;
      if ($urandom_range(1) == 0) c.read_address = 10'(recent_addr % ofc_pkg::STORE_SIZE);
    end
  endtask

  task automatic run_phase(input logic colour, input logic flip, input logic [14:0] thresh,
                           input int count);
    frame_cmd_t c;
    write_reg(ofc_pkg::CFG_COLOUR_SOURCE, 15'(colour));
    write_reg(ofc_pkg::CFG_BOTTOM_UP, 15'(flip));
    write_reg(ofc_pkg::CFG_LUMA_THRESHOLD, thresh);
    @(negedge clk);
    cfg_valid <= 1'b0;
    for (int n = 0; n < count; n++) begin
      random_word(flip, c);
      pending_q.push_back(c);
    end
    drain();
  endtask

  initial begin
    frame_cmd_t c;
    foreach (shadow_frame[a]) shadow_frame[a] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset register values
    push_read(10'd0);
    push_read(10'd1023);
    push_glyph(8'h61, 3'd0, 5'd0);          // lower case folds to upper
    push_read(10'd0);
    push_read(10'd4);
    push_glyph(8'h5a, 3'd7, 5'd20);         // last page, last text cell
    push_read(10'd1020);
    push_glyph(8'h39, 3'd3, 5'd5);
    push_glyph(8'hff, 3'd3, 5'd6);          // unknown code draws blank
    push_read(10'd414);
    push_glyph(8'h2e, 3'd1, 5'd1);
    push_glyph(8'h3a, 3'd1, 5'd2);
    push_glyph(8'h2d, 3'd1, 5'd3);
    push_glyph(8'h2f, 3'd1, 5'd4);
    push_glyph(8'h3e, 3'd1, 5'd5);
    push_glyph(8'h58, 3'd2, 5'd21);         // text column out of range
    push_glyph(8'h58, 3'd2, 5'd31);
    push_read(10'd382);
    push_pixel(7'd0, 6'd0, 8'h00, 8'h00, 8'h00);
    push_pixel(7'd127, 6'd63, 8'hff, 8'hff, 8'hff);
    push_pixel(7'd127, 6'd63, 8'h00, 8'h00, 8'hff);
    push_read(10'd896);
    push_read(10'd127);
    c = '0;
    c.kind = ofc_pkg::KIND_CLEAR;
    pending_q.push_back(c);
    push_read(10'd896);
    drain();

    // Random phases over several register settings
    run_phase(1'b0, 1'b0, 15'd0, ITEMS_PER_PHASE);
    run_phase(1'b1, 1'b0, 15'd25500, ITEMS_PER_PHASE);
    run_phase(1'b1, 1'b1, 15'h7fff, ITEMS_PER_PHASE);
    run_phase(1'b0, 1'b1, 15'($urandom_range(25500)), ITEMS_PER_PHASE);
    run_phase(1'b1, 1'b1, 15'd0, ITEMS_PER_PHASE);
    run_phase(1'b1, 1'b0, 15'($urandom_range(25500)), ITEMS_PER_PHASE);

    // Catch any stray result word before the verdict
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ofc_pkg.sv
hdl/ofc_if.sv
hdl/ofc_pixel_unit.sv
hdl/ofc_frame_engine.sv
hdl/oled_page_frame_composer.sv
hdl/ofc_checker.sv
bench/tb_oled_page_frame_composer.sv
